// ===== design/mspd_pkg.sv =====
// Shared types, constants and helper functions for the mirror scanner point-to-DMX core.
// No dependencies; every other design file except mspd_ifs imports this package.
`timescale 1ns / 1ps

package mspd_pkg;

  // Datapath widths: coordinates carry cm scaled by 2^14, angles 2^-16 degree.
  localparam int CW = 40;
  localparam int AW = 28;
  localparam int CFG_IDX_W = 4;
  localparam int QW = 48;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t DEG90  = 28'sd5898240;
  localparam ang_t DEG180 = 28'sd11796480;
  localparam ang_t DEG360 = 28'sd23592960;

  // Inverse CORDIC gain, Q30.
  localparam logic signed [30:0] INVK   = 31'sd652032874;
  localparam logic [29:0]        INVK_U = 30'd652032874;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Z       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOM_ROT    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_TILT  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_GAIN    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_GAIN   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_OFFSET = 4'd7;

  typedef struct packed {
    logic all_zero;
    logic yz_zero;
  } zflags_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } byte_res_t;

  // Arctangent of 2^-i in 2^-16 degree.
  function automatic ang_t atan_lut(input logic [4:0] i);
    ang_t r;
    case (i)
      5'd0:  r = 28'sd2949120;
      5'd1:  r = 28'sd1740967;
      5'd2:  r = 28'sd919879;
      5'd3:  r = 28'sd466945;
      5'd4:  r = 28'sd234379;
      5'd5:  r = 28'sd117304;
      5'd6:  r = 28'sd58666;
      5'd7:  r = 28'sd29335;
      5'd8:  r = 28'sd14668;
      5'd9:  r = 28'sd7334;
      5'd10: r = 28'sd3667;
      5'd11: r = 28'sd1833;
      5'd12: r = 28'sd917;
      5'd13: r = 28'sd458;
      5'd14: r = 28'sd229;
      5'd15: r = 28'sd115;
      5'd16: r = 28'sd57;
      5'd17: r = 28'sd29;
      5'd18: r = 28'sd14;
      5'd19: r = 28'sd7;
      5'd20: r = 28'sd4;
      5'd21: r = 28'sd2;
      5'd22: r = 28'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Register angle (1/64 degree) to 2^-16 degree, wrapped into (-180, 180].
  function automatic ang_t wrap_angle(input logic signed [15:0] r);
    ang_t a;
    a = ang_t'(r) <<< 10;
    if (a > DEG180) begin
      a = a - DEG360;
    end else if (a <= -DEG180) begin
      a = a + DEG360;
    end
    return a;
  endfunction

  // Q24 to byte: round half away from zero, then clamp to 0..255.
  function automatic byte_res_t to_byte(input logic signed [QW-1:0] q);
    logic signed [QW-1:0] mag;
    logic signed [24:0]   r;
    byte_res_t            res;
    mag = -q;
    if (q >= 0) begin
      r = 25'((q + 48'sd8388608) >>> 24);
    end else begin
      r = -25'((mag + 48'sd8388608) >>> 24);
    end
    res.ok = 1'b1;
    if (r < 0) begin
      res.ok  = 1'b0;
      res.val = 8'd0;
    end else if (r > 25'sd255) begin
      res.ok  = 1'b0;
      res.val = 8'd255;
    end else begin
      res.val = r[7:0];
    end
    return res;
  endfunction

endpackage

// ===== design/mspd_ifs.sv =====
// Handshake interfaces for target points, DMX results and configuration writes.
// Depends on nothing but the field widths of the core.
`timescale 1ns / 1ps

interface mspd_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;
  modport source (output valid, target_x, target_y, target_z, input ready);
  modport sink   (input valid, target_x, target_y, target_z, output ready);
endinterface

interface mspd_dmx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tilt_dmx;
  logic [7:0] pan_dmx;
  logic       reachable;
  modport source (output valid, tilt_dmx, pan_dmx, reachable, input ready);
  modport sink   (input valid, tilt_dmx, pan_dmx, reachable, output ready);
endinterface

interface mspd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [16:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/mspd_comp.sv =====
// Two-stage multiply by the inverse CORDIC gain with rounding.
// Depends on mspd_pkg; the wide product is split into two partial products.
`timescale 1ns / 1ps

module mspd_comp (
  input  logic                clk_i,
  input  logic                en_i,
  input  mspd_pkg::coord_t    v_i,
  output mspd_pkg::coord_t    v_o
);
  import mspd_pkg::*;

  logic signed [CW-21:0] hi;
  logic [19:0]           lo;
  logic signed [50:0]    ph_q;
  logic [49:0]           pl_q;
  logic signed [71:0]    sum;
  coord_t                v_q;

  assign hi = v_i[CW-1:20];
  assign lo = v_i[19:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q <= hi * INVK;
      pl_q <= lo * INVK_U;
    end
  end

  assign sum = (72'(ph_q) <<< 20) + 72'($signed({1'b0, pl_q})) + (72'sd1 <<< 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= sum[30+CW-1:30];
    end
  end

  assign v_o = v_q;
endmodule

// ===== design/mspd_rot.sv =====
// Pipelined rotation-mode CORDIC: one stage per iteration, then gain compensation.
// Depends on mspd_pkg and mspd_comp; a sideband word travels alongside.
`timescale 1ns / 1ps

module mspd_rot #(
  parameter int CORDIC_STEPS = 16,
  parameter int SW = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mspd_pkg::coord_t  a_i,
  input  mspd_pkg::coord_t  b_i,
  input  mspd_pkg::ang_t    ang_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output mspd_pkg::coord_t  a_o,
  output mspd_pkg::coord_t  b_o,
  output logic [SW-1:0]     side_o
);
  import mspd_pkg::*;

  coord_t               a_q [CORDIC_STEPS+1];
  coord_t               b_q [CORDIC_STEPS+1];
  ang_t                 z_q [CORDIC_STEPS+1];
  logic [SW-1:0]        s_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] v_q;
  logic [SW-1:0]        sd_q [2];
  logic [1:0]           vd_q;

  // Fold angles beyond a quarter turn by negating the vector.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= side_i;
      if (ang_i > DEG90) begin
        a_q[0] <= -a_i;
        b_q[0] <= -b_i;
        z_q[0] <= ang_i - DEG180;
      end else if (ang_i < -DEG90) begin
        a_q[0] <= -a_i;
        b_q[0] <= -b_i;
        z_q[0] <= ang_i + DEG180;
      end else begin
        a_q[0] <= a_i;
        b_q[0] <= b_i;
        z_q[0] <= ang_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    coord_t as;
    coord_t bs;
    assign as = a_q[k] >>> k;
    assign bs = b_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1] <= s_q[k];
        if (z_q[k] >= 0) begin
          a_q[k+1] <= a_q[k] - bs;
          b_q[k+1] <= b_q[k] + as;
          z_q[k+1] <= z_q[k] - atan_lut(5'(k));
        end else begin
          a_q[k+1] <= a_q[k] + bs;
          b_q[k+1] <= b_q[k] - as;
          z_q[k+1] <= z_q[k] + atan_lut(5'(k));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  mspd_comp u_comp_a (.clk_i(clk_i), .en_i(en_i), .v_i(a_q[CORDIC_STEPS]), .v_o(a_o));
  mspd_comp u_comp_b (.clk_i(clk_i), .en_i(en_i), .v_i(b_q[CORDIC_STEPS]), .v_o(b_o));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= s_q[CORDIC_STEPS];
      sd_q[1] <= sd_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else if (en_i) begin
      vd_q <= {vd_q[0], v_q[CORDIC_STEPS]};
    end
  end

  assign valid_o = vd_q[1];
  assign side_o  = sd_q[1];
endmodule

// ===== design/mspd_vec.sv =====
// Pipelined vectoring-mode CORDIC giving atan2 and the compensated magnitude.
// Depends on mspd_pkg and mspd_comp; a sideband word travels alongside.
`timescale 1ns / 1ps

module mspd_vec #(
  parameter int CORDIC_STEPS = 16,
  parameter int SW = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  mspd_pkg::coord_t  x_i,
  input  mspd_pkg::coord_t  y_i,
  input  logic [SW-1:0]     side_i,
  output logic              valid_o,
  output mspd_pkg::ang_t    z_o,
  output mspd_pkg::coord_t  mag_o,
  output logic [SW-1:0]     side_o
);
  import mspd_pkg::*;

  coord_t               x_q [CORDIC_STEPS+1];
  coord_t               y_q [CORDIC_STEPS+1];
  ang_t                 z_q [CORDIC_STEPS+1];
  logic [SW-1:0]        s_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] v_q;
  logic [SW-1:0]        sd_q [2];
  ang_t                 zd_q [2];
  logic [1:0]           vd_q;

  // Vectors in the left half plane are turned by a quarter first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= side_i;
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= DEG90;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -DEG90;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
    coord_t xs;
    coord_t ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1] <= s_q[k];
        if (y_q[k] >= 0) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + atan_lut(5'(k));
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - atan_lut(5'(k));
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
  end

  mspd_comp u_comp (.clk_i(clk_i), .en_i(en_i), .v_i(x_q[CORDIC_STEPS]), .v_o(mag_o));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= s_q[CORDIC_STEPS];
      sd_q[1] <= sd_q[0];
      zd_q[0] <= z_q[CORDIC_STEPS];
      zd_q[1] <= zd_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else if (en_i) begin
      vd_q <= {vd_q[0], v_q[CORDIC_STEPS]};
    end
  end

  assign valid_o = vd_q[1];
  assign side_o  = sd_q[1];
  assign z_o     = zd_q[1];
endmodule

// ===== design/mirror_scanner_point_to_dmx_core.sv =====
// Top level of the mirror scanner point-to-DMX core: configuration, pipeline glue, DMX mapping.
// Depends on mspd_pkg, the interfaces in mspd_ifs, mspd_rot and mspd_vec.
//
//   Channel  Direction  Word
//   in_i     sink       target_x, target_y, target_z (signed cm)
//   out_o    source     tilt_dmx, pan_dmx, reachable
//   cfg_i    sink       index (4 bits), data (17 bits)
//
// The core is a fully pipelined datapath that takes one word per clock unless
// stalled. Its depth is mostly set by the four CORDIC pipelines (one stage per
// iteration plus fold and gain stages).
// Reset clears every valid bit and loads the register defaults. The whole pipeline
// advances together: it holds only while the output register is full and not taken.
`timescale 1ns / 1ps

module mirror_scanner_point_to_dmx_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mspd_point_if.sink  in_i,
  mspd_dmx_if.source  out_o,
  mspd_cfg_if.sink    cfg_i
);
  import mspd_pkg::*;

  localparam int SW1 = CW + 2;
  localparam int SW2 = AW + 1;

  // Configuration registers.
  logic signed [15:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [15:0] room_rot_q, mount_tilt_q;
  logic signed [15:0] pan_gain_q, tilt_gain_q;
  logic signed [16:0] tilt_offset_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q       <= '0;
      pos_y_q       <= '0;
      pos_z_q       <= '0;
      room_rot_q    <= '0;
      mount_tilt_q  <= '0;
      pan_gain_q    <= 16'sd256;
      tilt_gain_q   <= 16'sd256;
      tilt_offset_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_POS_X:       pos_x_q       <= cfg_i.data[15:0];
        CFG_POS_Y:       pos_y_q       <= cfg_i.data[15:0];
        CFG_POS_Z:       pos_z_q       <= cfg_i.data[15:0];
        CFG_ROOM_ROT:    room_rot_q    <= cfg_i.data[15:0];
        CFG_MOUNT_TILT:  mount_tilt_q  <= cfg_i.data[15:0];
        CFG_PAN_GAIN:    pan_gain_q    <= cfg_i.data[15:0];
        CFG_TILT_GAIN:   tilt_gain_q   <= cfg_i.data[15:0];
        CFG_TILT_OFFSET: tilt_offset_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The rotation angles are to change only while the core is idle (the core does not
  // enforce this), so they feed the CORDIC fold stages directly, not with each word.
  ang_t room_ang, tilt_ang;
  assign room_ang = wrap_angle(room_rot_q);
  assign tilt_ang = wrap_angle(mount_tilt_q);

  // Global advance: everything moves unless a finished word waits at the output.
  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // Offset from the scanner, scaled by 2^14; z is flipped.
  logic signed [16:0] dx, dy, dz;
  coord_t s0_x_q, s0_y_q, s0_z_q;
  logic   s0_v_q;

  assign dx = 17'(in_i.target_x) - 17'(pos_x_q);
  assign dy = 17'(in_i.target_y) - 17'(pos_y_q);
  assign dz = 17'(pos_z_q) - 17'(in_i.target_z);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q <= CW'(dx) <<< 14;
      s0_y_q <= CW'(dy) <<< 14;
      s0_z_q <= CW'(dz) <<< 14;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= in_i.valid;
    end
  end

  // Rotate about the room vertical (x, y), z rides along.
  logic   r1_v;
  coord_t r1_x, r1_y;
  logic [CW-1:0] r1_z;

  mspd_rot #(.CORDIC_STEPS(CORDIC_STEPS), .SW(CW)) u_rot_room (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s0_v_q),
    .a_i    (s0_x_q),
    .b_i    (s0_y_q),
    .ang_i  (room_ang),
    .side_i (s0_z_q),
    .valid_o(r1_v),
    .a_o    (r1_x),
    .b_o    (r1_y),
    .side_o (r1_z)
  );

  // Flip x, then rotate by the mount tilt in the (x, z) plane; y rides along.
  logic   r2_v;
  coord_t r2_x, r2_z;
  logic [CW-1:0] r2_y;

  mspd_rot #(.CORDIC_STEPS(CORDIC_STEPS), .SW(CW)) u_rot_tilt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(r1_v),
    .a_i    (-r1_x),
    .b_i    (coord_t'(r1_z)),
    .ang_i  (tilt_ang),
    .side_i (r1_y),
    .valid_o(r2_v),
    .a_o    (r2_x),
    .b_o    (r2_z),
    .side_o (r2_y)
  );

  // Detect the degenerate directions and take |z| for the pan vectoring.
  coord_t  s1_x_q, s1_y_q, s1_absz_q;
  zflags_t s1_f_q;
  logic    s1_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q           <= r2_x;
      s1_y_q           <= coord_t'(r2_y);
      s1_absz_q        <= (r2_z < 0) ? -r2_z : r2_z;
      s1_f_q.yz_zero   <= (r2_y == '0) && (r2_z == '0);
      s1_f_q.all_zero  <= (r2_x == '0) && (r2_y == '0) && (r2_z == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= r2_v;
    end
  end

  // Pan: atan2(y, |z|); its magnitude becomes the radial term for tilt.
  logic     v1_v;
  ang_t     v1_z;
  coord_t   v1_mag;
  logic [SW1-1:0] v1_side;
  zflags_t  v1_f;
  coord_t   v1_x;

  mspd_vec #(.CORDIC_STEPS(CORDIC_STEPS), .SW(SW1)) u_vec_pan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s1_v_q),
    .x_i    (s1_absz_q),
    .y_i    (s1_y_q),
    .side_i ({s1_f_q, s1_x_q}),
    .valid_o(v1_v),
    .z_o    (v1_z),
    .mag_o  (v1_mag),
    .side_o (v1_side)
  );

  assign v1_f = v1_side[SW1-1:CW];
  assign v1_x = v1_side[CW-1:0];

  // A vector on the scanner axis has no pan and no radial part.
  ang_t   s2_pan_q;
  coord_t s2_rho_q, s2_x_q;
  logic   s2_all_zero_q;
  logic   s2_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pan_q      <= v1_f.yz_zero ? '0 : -v1_z;
      s2_rho_q      <= v1_f.yz_zero ? '0 : v1_mag;
      s2_x_q        <= v1_x;
      s2_all_zero_q <= v1_f.all_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= v1_v;
    end
  end

  // Theta: angle between the vector and the scanner x axis.
  logic     v2_v;
  ang_t     v2_z;
  logic [SW2-1:0] v2_side;

  mspd_vec #(.CORDIC_STEPS(CORDIC_STEPS), .SW(SW2)) u_vec_theta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s2_v_q),
    .x_i    (s2_x_q),
    .y_i    (s2_rho_q),
    .side_i ({s2_all_zero_q, s2_pan_q}),
    .valid_o(v2_v),
    .z_o    (v2_z),
    .mag_o  (),
    .side_o (v2_side)
  );

  // Tilt is ninety degrees less half of theta; a target at the scanner
  // counts as theta of ninety degrees.
  ang_t theta;
  ang_t s3_tilt_q, s3_pan_q;
  logic s3_v_q;

  assign theta = v2_side[SW2-1] ? DEG90 : v2_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_tilt_q <= DEG90 - (theta >>> 1);
      s3_pan_q  <= v2_side[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= v2_v;
    end
  end

  // Gain products in Q24.
  logic signed [AW+15:0] s4_tp_q, s4_pp_q;
  logic                  s4_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_tp_q <= tilt_gain_q * s3_tilt_q;
      s4_pp_q <= pan_gain_q * s3_pan_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  // Add offsets, round and clamp into the output register.
  logic signed [QW-1:0] tilt_q24, pan_q24;
  byte_res_t            tilt_b, pan_b;
  logic [7:0]           tilt_q, pan_q;
  logic                 reach_q;

  assign tilt_q24 = (QW'(tilt_offset_q) <<< 16) + QW'(s4_tp_q);
  assign pan_q24  = (48'sd128 <<< 24) + QW'(s4_pp_q);
  assign tilt_b   = to_byte(tilt_q24);
  assign pan_b    = to_byte(pan_q24);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tilt_q  <= tilt_b.val;
      pan_q   <= pan_b.val;
      reach_q <= tilt_b.ok && pan_b.ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s4_v_q;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.tilt_dmx  = tilt_q;
  assign out_o.pan_dmx   = pan_q;
  assign out_o.reachable = reach_q;
endmodule
